// ===== design/qdds_pkg.sv =====
// ----------------------------------------------------------------------------
// qdds_pkg
// Shared widths, constants, register map and quarter-wave sine generator
// for the quadrature DDS with output clipping.
// ----------------------------------------------------------------------------
package qdds_pkg;

  // core sizes
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 12;
  localparam int DAC_BITS        = 12;
  localparam int UNIT_BITS       = 16;
  localparam int AMP_BITS        = 10;
  localparam int GAIN_BITS       = 12;
  localparam int BOUND_BITS      = 12;
  localparam int WORD_BITS       = 16;

  // configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_INC = 3'd0,
    REG_AMPLITUDE = 3'd1,
    REG_CLIP_EN   = 3'd2,
    REG_LO_A      = 3'd3,
    REG_HI_A      = 3'd4,
    REG_LO_B      = 3'd5,
    REG_HI_B      = 3'd6
  } cfg_reg_t;

  // quarter-wave table
  localparam int QSIZE      = 1 << (TABLE_ADDR_BITS - 2);
  localparam int ROM_ADDR_W = TABLE_ADDR_BITS - 1;

  // datapath widths
  localparam int UNIT_W = UNIT_BITS + 2;            // signed unit value
  localparam int AG_W   = AMP_BITS + GAIN_BITS;     // amplitude times gain
  localparam int PROD_W = AG_W + 1 + UNIT_W;        // signed product
  localparam int NUM_W  = PROD_W + 1;               // signed numerator
  localparam int HI_W   = NUM_W - 1 - UNIT_BITS;    // numerator above the unit scale

  // scale by 1000 mV per volt
  localparam int     MV_PER_VOLT = 1000;
  localparam longint DEN         = longint'(MV_PER_VOLT) << UNIT_BITS;
  localparam int     QUO_W       = DAC_BITS + 10;   // n/2^16 stays below 2^QUO_W
  localparam longint RECIP       = (longint'(1) << QUO_W) / MV_PER_VOLT;
  localparam int     RECIP_W     = $clog2(RECIP + 1);
  localparam longint SAT_LIMIT   = longint'(MV_PER_VOLT) << DAC_BITS;

  // per-channel constants, channel A is cosine, channel B is sine
  localparam int NUM_CH = 2;
  localparam int CH_A   = 0;
  localparam int CH_B   = 1;

  localparam int GAIN_A   = 4042;
  localparam int OFFSET_A = 2152;
  localparam int GAIN_B   = 4020;
  localparam int OFFSET_B = 2121;

  localparam logic [GAIN_BITS-1:0] CH_GAIN [NUM_CH] = '{
    GAIN_BITS'(GAIN_A), GAIN_BITS'(GAIN_B)
  };
  localparam logic signed [NUM_W-1:0] CH_OFFSET_SCALED [NUM_CH] = '{
    NUM_W'(longint'(OFFSET_A) * DEN), NUM_W'(longint'(OFFSET_B) * DEN)
  };
  localparam logic [WORD_BITS-1:0] CH_CMD [NUM_CH] = '{16'h7000, 16'hF000};

  // sine polynomial coefficients, unsigned Q30
  localparam logic [63:0] Q30_C1 = 64'd1686629713;
  localparam logic [63:0] Q30_C3 = 64'd693598670;
  localparam logic [63:0] Q30_C5 = 64'd85569306;
  localparam logic [63:0] Q30_C7 = 64'd5026995;
  localparam logic [63:0] Q30_C9 = 64'd172271;

  typedef logic        [UNIT_BITS:0]  qsine_t;
  typedef logic signed [UNIT_W-1:0]   unit_t;
  typedef logic        [AG_W-1:0]     amp_gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic        [QUO_W-1:0]    quo_t;
  typedef logic        [DAC_BITS-1:0] code_t;

  // sin(pi/2 * k / QSIZE) in Q16, truncating Horner form, capped at 1.0
  function automatic qsine_t quarter_sine(input logic [ROM_ADDR_W-1:0] k);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    u  = 64'(k) << (30 - (TABLE_ADDR_BITS - 2));
    u2 = (u * u) >> 30;
    t  = Q30_C9;
    t  = Q30_C7 - ((t * u2) >> 30);
    t  = Q30_C5 - ((t * u2) >> 30);
    t  = Q30_C3 - ((t * u2) >> 30);
    t  = Q30_C1 - ((t * u2) >> 30);
    s  = (t * u) >> 30;
    s  = (s + (64'd1 << 13)) >> 14;
    if (s > (64'd1 << UNIT_BITS)) begin
      s = 64'd1 << UNIT_BITS;
    end
    return s[UNIT_BITS:0];
  endfunction

endpackage

// ===== design/quadrature_dds_with_clipping.sv =====
// ----------------------------------------------------------------------------
// quadrature_dds_with_clipping
// Quadrature NCO driving two 12-bit DAC channels with optional code clamping.
// ----------------------------------------------------------------------------
// Each request with tick high advances the 32-bit phase accumulator by
// phase_increment and yields one result: a cosine command word on word_a
// (0x7000 nibble), a sine command word on word_b (0xF000 nibble) and the top
// 12 phase bits on table_index. A request with tick low is taken but leaves
// the phase alone and produces nothing. The block takes one request per clock
// while in_ready is high; each result passes through the datapath stages in
// order: quarter-wave ROM read, quadrant fold with amplitude scaling,
// one signed multiply, offset subtract, reciprocal multiply, remainder fixup,
// then clamp and pack into the output register. The sine ROM holds 1025
// quarter-wave points, built at elaboration, and is read at two addresses
// per request (near and far side of the quadrant). Back pressure from
// out_ready collapses bubbles stage by stage, so in_ready drops only once
// every stage holds a result. Registers are written through cfg_write_en,
// cfg_index and cfg_data; unknown indexes are ignored. A phase_increment
// write on the same edge as a request is seen by that request.
// ----------------------------------------------------------------------------
module quadrature_dds_with_clipping (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_write_en,
  input  logic [qdds_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qdds_pkg::CFG_DATA_W-1:0]      cfg_data,
  // tick requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 tick,
  // DAC words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [qdds_pkg::WORD_BITS-1:0]       word_a,
  output logic [qdds_pkg::WORD_BITS-1:0]       word_b,
  output logic [qdds_pkg::TABLE_ADDR_BITS-1:0] table_index
);
  import qdds_pkg::*;

  localparam int NSTAGE = 7;

  // configuration registers
  logic [CFG_DATA_W-1:0] phase_increment;
  logic [AMP_BITS-1:0]   amplitude_mv;
  logic                  clip_enable;
  logic [BOUND_BITS-1:0] lower_bound_a;
  logic [BOUND_BITS-1:0] upper_bound_a;
  logic [BOUND_BITS-1:0] lower_bound_b;
  logic [BOUND_BITS-1:0] upper_bound_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      amplitude_mv    <= '0;
      clip_enable     <= 1'b0;
      lower_bound_a   <= '0;
      upper_bound_a   <= '1;
      lower_bound_b   <= '0;
      upper_bound_b   <= '1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PHASE_INC: phase_increment <= cfg_data;
        REG_AMPLITUDE: amplitude_mv    <= cfg_data[AMP_BITS-1:0];
        REG_CLIP_EN:   clip_enable     <= cfg_data[0];
        REG_LO_A:      lower_bound_a   <= cfg_data[BOUND_BITS-1:0];
        REG_HI_A:      upper_bound_a   <= cfg_data[BOUND_BITS-1:0];
        REG_LO_B:      lower_bound_b   <= cfg_data[BOUND_BITS-1:0];
        REG_HI_B:      upper_bound_b   <= cfg_data[BOUND_BITS-1:0];
        default: ;  // index outside the register map
      endcase
    end
  end

  // stage valids and advance enables, bubbles collapse toward the output
  logic [NSTAGE:1] v;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !v[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NSTAGE];

  logic accept;
  logic take;
  assign accept = in_valid && in_ready;
  assign take   = accept && tick;

  // phase accumulator; a same-edge increment write is forwarded
  logic [PHASE_BITS-1:0]      phase;
  logic [CFG_DATA_W-1:0]      inc_eff;
  logic [PHASE_BITS-1:0]      phase_next;
  logic [TABLE_ADDR_BITS-1:0] idx_next;
  logic [ROM_ADDR_W-1:0]      near_addr;
  logic [ROM_ADDR_W-1:0]      far_addr;

  always_comb begin
    inc_eff = phase_increment;
    if (cfg_write_en && (cfg_index == REG_PHASE_INC)) begin
      inc_eff = cfg_data;
    end
    phase_next = phase + PHASE_BITS'(inc_eff);
    idx_next   = phase_next[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    // offset within the quadrant and its mirror
    near_addr  = ROM_ADDR_W'(idx_next[TABLE_ADDR_BITS-3:0]);
    far_addr   = ROM_ADDR_W'(QSIZE) - near_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      v     <= '0;
    end else begin
      if (take) begin
        phase <= phase_next;
      end
      if (en[1]) begin
        v[1] <= take;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // quarter-wave sine ROM, contents fixed at elaboration
  qsine_t qsine_rom [QSIZE+1];

  for (genvar k = 0; k <= QSIZE; k++) begin : g_rom
    assign qsine_rom[k] = quarter_sine(ROM_ADDR_W'(k));
  end

  // pipeline payload
  qsine_t                     near1, far1;
  logic [TABLE_ADDR_BITS-1:0] idx1, idx2, idx3, idx4, idx5, idx6;
  unit_t                      unit2 [NUM_CH];
  amp_gain_t                  ag2   [NUM_CH];
  prod_t                      prod3 [NUM_CH];
  quo_t                       n16_4 [NUM_CH];
  logic                       neg4  [NUM_CH];
  logic                       sat4  [NUM_CH];
  quo_t                       n16_5 [NUM_CH];
  code_t                      q0_5  [NUM_CH];
  logic                       neg5  [NUM_CH];
  logic                       sat5  [NUM_CH];
  code_t                      code6 [NUM_CH];

  // quadrant fold: sin magnitude is far on odd quadrants, cos the other one
  logic [1:0] quad1;
  unit_t      near_s, far_s;
  unit_t      unit_sel [NUM_CH];

  always_comb begin
    quad1  = idx1[TABLE_ADDR_BITS-1 -: 2];
    near_s = signed'({1'b0, near1});
    far_s  = signed'({1'b0, far1});
    unit_sel[CH_A] = quad1[0] ? near_s : far_s;
    if (quad1[1] ^ quad1[0]) begin
      unit_sel[CH_A] = -unit_sel[CH_A];
    end
    unit_sel[CH_B] = quad1[0] ? far_s : near_s;
    if (quad1[1]) begin
      unit_sel[CH_B] = -unit_sel[CH_B];
    end
  end

  // offset minus scaled product, split into sign, overflow and n / 2^16
  logic signed [NUM_W-1:0] num3 [NUM_CH];
  logic [HI_W-1:0]         hi3  [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      num3[ch] = CH_OFFSET_SCALED[ch] - NUM_W'(prod3[ch]);
      hi3[ch]  = num3[ch][NUM_W-2:UNIT_BITS];
    end
  end

  // floor divide by 1000 through the reciprocal, low by at most one
  logic [QUO_W+RECIP_W-1:0] recip_prod4 [NUM_CH];
  quo_t                     rem5        [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      recip_prod4[ch] = (QUO_W+RECIP_W)'(n16_4[ch]) * (QUO_W+RECIP_W)'(RECIP);
      rem5[ch] = n16_5[ch] - QUO_W'(QUO_W'(q0_5[ch]) * QUO_W'(MV_PER_VOLT));
    end
  end

  // clamp to the configured window
  code_t lo6 [NUM_CH];
  code_t hi6 [NUM_CH];
  code_t clip6 [NUM_CH];

  always_comb begin
    lo6[CH_A] = DAC_BITS'(lower_bound_a);
    hi6[CH_A] = DAC_BITS'(upper_bound_a);
    lo6[CH_B] = DAC_BITS'(lower_bound_b);
    hi6[CH_B] = DAC_BITS'(upper_bound_b);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      clip6[ch] = code6[ch];
      if (clip_enable) begin
        if (code6[ch] < lo6[ch]) begin
          clip6[ch] = lo6[ch];
        end else if (code6[ch] > hi6[ch]) begin
          clip6[ch] = hi6[ch];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: ROM read at both quadrant addresses
    if (en[1]) begin
      near1 <= qsine_rom[near_addr];
      far1  <= qsine_rom[far_addr];
      idx1  <= idx_next;
    end
    // stage 2: signed unit values and amplitude times gain
    if (en[2]) begin
      idx2 <= idx1;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        unit2[ch] <= unit_sel[ch];
        ag2[ch]   <= AG_W'(AG_W'(amplitude_mv) * AG_W'(CH_GAIN[ch]));
      end
    end
    // stage 3: scale the unit value
    if (en[3]) begin
      idx3 <= idx2;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod3[ch] <= signed'({1'b0, ag2[ch]}) * unit2[ch];
      end
    end
    // stage 4: negative and saturation checks
    if (en[4]) begin
      idx4 <= idx3;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        neg4[ch]  <= num3[ch][NUM_W-1];
        sat4[ch]  <= !num3[ch][NUM_W-1] && (hi3[ch] >= HI_W'(SAT_LIMIT));
        n16_4[ch] <= hi3[ch][QUO_W-1:0];
      end
    end
    // stage 5: quotient estimate
    if (en[5]) begin
      idx5 <= idx4;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        q0_5[ch]  <= recip_prod4[ch][QUO_W +: DAC_BITS];
        n16_5[ch] <= n16_4[ch];
        neg5[ch]  <= neg4[ch];
        sat5[ch]  <= sat4[ch];
      end
    end
    // stage 6: remainder fixup and saturation
    if (en[6]) begin
      idx6 <= idx5;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (neg5[ch]) begin
          code6[ch] <= '0;
        end else if (sat5[ch]) begin
          code6[ch] <= '1;
        end else if (rem5[ch] >= QUO_W'(MV_PER_VOLT)) begin
          code6[ch] <= q0_5[ch] + 1'b1;
        end else begin
          code6[ch] <= q0_5[ch];
        end
      end
    end
    // stage 7: output register, clamp and pack command words
    if (en[7]) begin
      table_index <= idx6;
      word_a      <= CH_CMD[CH_A] | WORD_BITS'(clip6[CH_A]);
      word_b      <= CH_CMD[CH_B] | WORD_BITS'(clip6[CH_B]);
    end
  end

  // a request with tick low leaves the phase untouched
  a_idle_tick_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !tick) |=> $stable(phase))
    else $error("phase moved on a request without tick");

  // with the output register empty nothing upstream may stall
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // input stalls only once every stage is occupied
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input stalled with a bubble in the pipeline");

  // a stalled multiply stage keeps its result
  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (v[3] && !en[3]) |=> (v[3] && $stable(prod3[CH_A]) && $stable(prod3[CH_B])))
    else $error("stalled product stage lost its contents");

endmodule

// ===== tb/quadrature_dds_with_clipping_tb.sv =====
// ----------------------------------------------------------------------------
// quadrature_dds_with_clipping_tb
// Self-checking bench for the quadrature DDS with output clamping: a
// scoreboard rebuilds the quarter-wave table, tracks the phase accumulator
// and predicts both DAC command words for every accepted tick request.
// ----------------------------------------------------------------------------
module quadrature_dds_with_clipping_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // bench sizing
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_TICKS    = 214;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // per idle profile: sender gap and receiver stall percentages
  localparam int SEND_IDLE  [4] = '{0, 51, 0, 29};
  localparam int RECV_STALL [4] = '{0, 0, 51, 29};

  // register index that maps to nothing, writes must be dropped
  localparam logic [qdds_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // predictor constants: sine polynomial in unsigned Q30 and channel scaling
  localparam logic [63:0] SIN_K1 = 64'd1686629713;
  localparam logic [63:0] SIN_K3 = 64'd693598670;
  localparam logic [63:0] SIN_K5 = 64'd85569306;
  localparam logic [63:0] SIN_K7 = 64'd5026995;
  localparam logic [63:0] SIN_K9 = 64'd172271;
  localparam int     QUARTER    = 1024;
  localparam longint SCALE_DEN  = 64'd65536000;   // 1000 mV times Q16 unit
  localparam longint COS_GAIN   = 4042;
  localparam longint COS_OFFSET = 2152;
  localparam longint SIN_GAIN   = 4020;
  localparam longint SIN_OFFSET = 2121;
  localparam logic [15:0] CMD_NIBBLE_A = 16'h7000;
  localparam logic [15:0] CMD_NIBBLE_B = 16'hF000;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quadrant_t;

  typedef struct packed {
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [11:0] index;
  } dac_sample_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the registers and phase, queue of DAC samples
  // --------------------------------------------------------------------------
  class dds_scoreboard;
    logic [31:0] step_size;
    logic [9:0]  amp_mv;
    logic        clamp_on;
    logic [11:0] lo_a, hi_a, lo_b, hi_b;
    logic [31:0] phase;
    logic [16:0] quarter_wave [0:QUARTER];
    dac_sample_t expected_samples [$];
    int mismatches;
    int results_seen;
    int ticks_taken;
    int idle_ticks;

    function new();
      logic [63:0] u, u2, t, s;
      // sin(pi/2 * k/1024) by truncating Horner steps, rounded to Q16
      for (int k = 0; k <= QUARTER; k++) begin
        u  = 64'(k) << 20;
        u2 = (u * u) >> 30;
        t  = SIN_K9;
        t  = SIN_K7 - ((t * u2) >> 30);
        t  = SIN_K5 - ((t * u2) >> 30);
        t  = SIN_K3 - ((t * u2) >> 30);
        t  = SIN_K1 - ((t * u2) >> 30);
        s  = (t * u) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
          s = 64'd65536;
        end
        quarter_wave[k] = s[16:0];
      end
      step_size = '0;
      amp_mv    = '0;
      clamp_on  = 1'b0;
      lo_a      = '0;
      hi_a      = 12'd4095;
      lo_b      = '0;
      hi_b      = 12'd4095;
      phase     = '0;
    endfunction

    function void note_write(logic [qdds_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        qdds_pkg::REG_PHASE_INC: step_size = data;
        qdds_pkg::REG_AMPLITUDE: amp_mv    = data[9:0];
        qdds_pkg::REG_CLIP_EN:   clamp_on  = data[0];
        qdds_pkg::REG_LO_A:      lo_a      = data[11:0];
        qdds_pkg::REG_HI_A:      hi_a      = data[11:0];
        qdds_pkg::REG_LO_B:      lo_b      = data[11:0];
        qdds_pkg::REG_HI_B:      hi_b      = data[11:0];
        default: ;
      endcase
    endfunction

    // floor((offset*D - amp*gain*v)/D), saturated to the 12-bit code range
    function logic [11:0] dac_code(longint unit, longint gain, longint offset);
      longint num;
      num = offset * SCALE_DEN - longint'(amp_mv) * gain * unit;
      if (num < 0) begin
        return '0;
      end
      if (num / SCALE_DEN > 4095) begin
        return 12'd4095;
      end
      return 12'(num / SCALE_DEN);
    endfunction

    // crossed bounds: below lower gives lower, anything else gives upper
    function logic [11:0] clamp(logic [11:0] code, logic [11:0] lo, logic [11:0] hi);
      if (code < lo) begin
        return lo;
      end
      if (code > hi) begin
        return hi;
      end
      return code;
    endfunction

    function void note_request(logic tick_bit);
      dac_sample_t want;
      logic [11:0] idx;
      logic [9:0]  r;
      longint      near_v, far_v, c, s;
      logic [11:0] code_a, code_b;
      if (!tick_bit) begin
        idle_ticks++;
        return;
      end
      ticks_taken++;
      phase  = phase + step_size;
      idx    = phase[31:20];
      r      = idx[9:0];
      near_v = longint'(quarter_wave[r]);
      far_v  = longint'(quarter_wave[QUARTER - r]);
      case (quadrant_t'(idx[11:10]))
        QUAD_I: begin
          s = near_v;  c = far_v;
        end
        QUAD_II: begin
          s = far_v;   c = -near_v;
        end
        QUAD_III: begin
          s = -near_v; c = -far_v;
        end
        default: begin
          s = -far_v;  c = near_v;
        end
      endcase
      code_a = dac_code(c, COS_GAIN, COS_OFFSET);
      code_b = dac_code(s, SIN_GAIN, SIN_OFFSET);
      if (clamp_on) begin
        code_a = clamp(code_a, lo_a, hi_a);
        code_b = clamp(code_b, lo_b, hi_b);
      end
      want.word_a = CMD_NIBBLE_A | {4'd0, code_a};
      want.word_b = CMD_NIBBLE_B | {4'd0, code_b};
      want.index  = idx;
      expected_samples.push_back(want);
    endfunction

    function void check_result(logic [15:0] a, logic [15:0] b, logic [11:0] ix);
      dac_sample_t want;
      results_seen++;
      if (expected_samples.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected result a=%h b=%h index=%h with nothing pending",
                   $realtime, a, b, ix);
        end
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      if (want.word_a !== a || want.word_b !== b || want.index !== ix) begin
        if (mismatches < 10) begin
          $display("%0t: result mismatch: a exp %h got %h, b exp %h got %h, index exp %h got %h",
                   $realtime, want.word_a, a, want.word_b, b, want.index, ix);
        end
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 cfg_write_en = 1'b0;
  logic [qdds_pkg::CFG_INDEX_W-1:0]     cfg_index    = '0;
  logic [qdds_pkg::CFG_DATA_W-1:0]      cfg_data     = '0;
  logic                                 in_valid     = 1'b0;
  logic                                 in_ready;
  logic                                 tick         = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready    = 1'b0;
  logic [qdds_pkg::WORD_BITS-1:0]       word_a;
  logic [qdds_pkg::WORD_BITS-1:0]       word_b;
  logic [qdds_pkg::TABLE_ADDR_BITS-1:0] table_index;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quadrature_dds_with_clipping u_top (
    .clk,
    .rst,
    .cfg_write_en,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .tick,
    .out_valid,
    .out_ready,
    .word_a,
    .word_b,
    .table_index
  );

  dds_scoreboard sb;

  int send_idle        = 0;   // percent of cycles the sender holds back
  int recv_stall       = 0;   // percent of cycles the receiver stalls
  int settings_applied = 0;
  int quiet_cycles     = 0;

  // --------------------------------------------------------------------------
  // receiver side: random back pressure, and the result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // values read here are the ones that were stable before the edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(word_a, word_b, table_index);
    end
  end

  // watchdog: too long without any request or result moving ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles, %0d results pending",
               quiet_cycles, sb.expected_samples.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------

  // one request, with random sender gaps ahead of it; valid stays up after
  // acceptance so back-to-back requests need no second assignment
  task automatic send_request(input logic tick_bit);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= tick_bit;
    do @(posedge clk); while (!in_ready);
    sb.note_request(tick_bit);
  endtask

  // stop sending, wait for all pending results, then let the pipe go quiet
  task automatic hold_until_drained(input int tail);
    in_valid <= 1'b0;
    while (sb.expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (tail) @(posedge clk);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [qdds_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    sb.note_write(idx, data);
  endtask

  // full register image, plus a write to the unmapped index that must vanish
  task automatic apply_setting(input logic [31:0] inc, amp, clip,
                               input logic [31:0] lo_a, hi_a, lo_b, hi_b);
    write_reg(qdds_pkg::REG_PHASE_INC, inc);
    write_reg(qdds_pkg::REG_AMPLITUDE, amp);
    write_reg(qdds_pkg::REG_CLIP_EN,   clip);
    write_reg(qdds_pkg::REG_LO_A,      lo_a);
    write_reg(qdds_pkg::REG_HI_A,      hi_a);
    write_reg(qdds_pkg::REG_LO_B,      lo_b);
    write_reg(qdds_pkg::REG_HI_B,      hi_b);
    write_reg(REG_SPARE,               $urandom);
    cfg_write_en <= 1'b0;
    settings_applied++;
  endtask

  // half the time, set garbage above the register width to check masking
  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    logic [31:0] keep;
    keep = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
    return $urandom_range(1) ? ((v & keep) | ($urandom & ~keep)) : v;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] inc, lo_a, hi_a, lo_b, hi_b;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset image: zero step and amplitude, so both codes sit at their offsets;
    // a tick-low request must leave the phase alone and produce nothing
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    hold_until_drained(DRAIN_CYCLES);

    // quarter-turn steps at full amplitude: every quadrant boundary, and the
    // codes run off both ends of the DAC range
    apply_setting(32'h4000_0000, 1023, 0, 0, 4095, 0, 4095);
    repeat (4) send_request(1'b1);
    hold_until_drained(DRAIN_CYCLES);

    // largest step, clamping on with crossed channel A bounds
    apply_setting(32'hFFFF_FFFF, 1023, 1, 3000, 1000, 100, 4000);
    send_request(1'b1);
    send_request(1'b0);
    repeat (3) send_request(1'b1);
    hold_until_drained(DRAIN_CYCLES);

    // equal bounds pin both codes to one value
    apply_setting(32'h0123_4567, 500, 1, 2048, 2048, 2048, 2048);
    repeat (4) send_request(1'b1);

    // random phases, each with its own register image and idle profile
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle  = SEND_IDLE[p % 4];
      recv_stall = RECV_STALL[p % 4];
      hold_until_drained(DRAIN_CYCLES);
      if (p == 0) begin
        // register maxima, channel B bounds fully crossed
        apply_setting('1, 1023, 1, 0, 4095, 4095, 0);
      end else if (p == 1) begin
        // smallest nonzero step, no amplitude, crossed bounds left unused
        apply_setting(32'd1, 0, 0, 4095, 0, 0, 4095);
      end else begin
        // mostly full-range steps, sometimes a slow sweep
        inc = ($urandom_range(3) == 0) ? $urandom_range(65536, 1) : $urandom;
        if ($urandom_range(1)) begin
          lo_a = $urandom_range(2047);
          hi_a = $urandom_range(4095, 2048);
          lo_b = $urandom_range(2047);
          hi_b = $urandom_range(4095, 2048);
        end else begin
          lo_a = $urandom_range(4095);
          hi_a = $urandom_range(4095);
          lo_b = $urandom_range(4095);
          hi_b = $urandom_range(4095);
        end
        apply_setting(inc,
                      with_junk($urandom_range(1023), 10),
                      with_junk($urandom_range(1), 1),
                      with_junk(lo_a, 12), with_junk(hi_a, 12),
                      with_junk(lo_b, 12), with_junk(hi_b, 12));
      end

      for (int n = 0; n < PHASE_TICKS; n++) begin
        // halfway through, the sender waits for the pipe to empty
        if (n == PHASE_TICKS / 2) begin
          hold_until_drained(0);
        end
        // occasional tick-low request mixed in as noise
        if ($urandom_range(9) == 0) begin
          send_request(1'b0);
        end
        send_request(1'b1);
      end
    end

    // drain: watchdog bounds the wait, then a tail to catch stray results
    hold_until_drained(DRAIN_CYCLES);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d tick requests and %0d tick-low requests over %0d register images",
             sb.ticks_taken, sb.idle_ticks, settings_applied);
    $display("checked %0d results: %0d mismatches, %0d expected results never seen",
             sb.results_seen, sb.mismatches, sb.expected_samples.size());
    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== quadrature_dds_with_clipping.f =====
design/qdds_pkg.sv
design/quadrature_dds_with_clipping.sv
tb/quadrature_dds_with_clipping_tb.sv
